### design/conv3x3_nibble_pixels_assert.svh
`ifndef CONV3X3_NIBBLE_PIXELS_ASSERT_SVH
`define CONV3X3_NIBBLE_PIXELS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CNP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CNP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/cnp_pkg.sv
package cnp_pkg;

	localparam int PIX_W          = 4;
	localparam int PIX_MAX        = 15;
	localparam int DIM_W          = 10;
	localparam int COEF_W         = 10;
	localparam int KROW_W         = 3 * COEF_W;
	localparam int POS_W          = 9;
	localparam int COEF_FRAC_BITS = 6;
	localparam int ROWSUM_W       = COEF_W + PIX_W + 2;
	localparam int TOTAL_W        = ROWSUM_W + 2;

	typedef enum logic {
		CMD_PUSH  = 1'b0,
		CMD_FLUSH = 1'b1
	} cmd_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_FRAME_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT  = 3'd1,
		REG_KERNEL_TOP    = 3'd2,
		REG_KERNEL_MIDDLE = 3'd3,
		REG_KERNEL_BOTTOM = 3'd4
	} cfg_reg_t;

	typedef logic [2:0][2:0][PIX_W-1:0] grid_t;   // [row][col], row 0 on top, col 0 left

	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} pad_t;

	// one item leaving the counter stage
	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             emit;
		logic             last;
		pad_t             pad;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} pos_item_t;

	// padded neighborhood of one output pixel
	typedef struct packed {
		grid_t            grid;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} win_item_t;

	typedef struct packed {
		logic [KROW_W-1:0] bot;
		logic [KROW_W-1:0] mid;
		logic [KROW_W-1:0] top;
	} kernel_t;

	typedef struct packed {
		logic             last;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic [PIX_W-1:0] pixel;
	} result_t;

endpackage

### design/conv3x3_nibble_pixels.sv
// 3x3 convolution over a raster stream of 4-bit grey pixels. Each slave item is a
// pixel push (tuser 0) or a flush (tuser 1); the block accepts one item per clock
// unless output back-pressure holds it; each master item carries the filtered pixel
// at (row, col) and follows the item that completes its neighborhood. Output (r,c)
// leaves once input (r+1,c+1) is in; flushes feed zeros to drain the last row and a
// half, and a flush before the frame is complete is dropped. Sums use signed Q3.6
// coefficients, are truncated and clamped to 0..15, and pixels outside the frame
// count as zero. The line store is one synchronous memory holding both previous
// rows, read and written once per item; its registered read and the write-back of
// the same entry from the following stage set the stage split, with a bypass
// when consecutive items hit the same column. The store needs no clearing after
// reset. Frame size and kernel are written while no item is in flight.
module conv3x3_nibble_pixels import cnp_pkg::*; #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [29:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_pixel[3:0], zeros above
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_pixel[3:0], out_row[12:4], out_col[21:13], zeros above
	output logic        m_tlast    // frame_last
);

	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int PAD_W = 24 - 2*POS_W - PIX_W;

	localparam logic [DIM_W-1:0]  WIDTH_RESET  = DIM_W'(160);
	localparam logic [DIM_W-1:0]  HEIGHT_RESET = DIM_W'(120);
	localparam logic [KROW_W-1:0] KERNEL_RESET = {COEF_W'(7), COEF_W'(7), COEF_W'(7)};

	logic [DIM_W-1:0] cfg_width_q, cfg_height_q;
	kernel_t          kernel_q;
	logic             take, push, win_valid, mac_ready;
	logic [AW-1:0]    addr;
	pos_item_t        pos_item;
	win_item_t        win_item;
	result_t          result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= WIDTH_RESET;
			cfg_height_q <= HEIGHT_RESET;
			kernel_q.top <= KERNEL_RESET;
			kernel_q.mid <= KERNEL_RESET;
			kernel_q.bot <= KERNEL_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:   cfg_width_q  <= cfg_wdata[DIM_W-1:0];
				REG_FRAME_HEIGHT:  cfg_height_q <= cfg_wdata[DIM_W-1:0];
				REG_KERNEL_TOP:    kernel_q.top <= cfg_wdata;
				REG_KERNEL_MIDDLE: kernel_q.mid <= cfg_wdata;
				REG_KERNEL_BOTTOM: kernel_q.bot <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign take = s_tvalid && s_tready;

	cnp_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_width  (cfg_width_q),
		.cfg_height (cfg_height_q),
		.take       (take),
		.cmd        (s_tuser),
		.in_pixel   (s_tdata[PIX_W-1:0]),
		.push       (push),
		.addr       (addr),
		.item       (pos_item)
	);

	cnp_line_buf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.addr      (addr),
		.item      (pos_item),
		.in_ready  (s_tready),
		.out_valid (win_valid),
		.out_ready (mac_ready),
		.out_item  (win_item)
	);

	cnp_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.kernel    (kernel_q),
		.in_valid  (win_valid),
		.in_item   (win_item),
		.in_ready  (mac_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result    (result)
	);

	assign m_tdata = {{PAD_W{1'b0}}, result.col, result.row, result.pixel};
	assign m_tlast = result.last;

endmodule

### design/cnp_ctrl.sv
`include "conv3x3_nibble_pixels_assert.svh"

module cnp_ctrl import cnp_pkg::*; #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DIM_W-1:0] cfg_width,
	input  logic [DIM_W-1:0] cfg_height,
	input  logic             take,
	input  logic             cmd,
	input  logic [PIX_W-1:0] in_pixel,
	output logic             push,
	output logic [AW-1:0]    addr,
	output pos_item_t        item
);

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 2);

	logic [CW-1:0] ic_q, w_eff, ic0, ic_nxt, ocol;
	logic [RW-1:0] ir_q, h_eff, h_plus1, ir0, ir_nxt, orow;
	logic          restart, in_frame, drop, emit_edge, emit_main, emit, last;

	always_comb begin
		if (cfg_width == '0) begin
			w_eff = CW'(1);
		end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(cfg_width);
		end
		if (cfg_height == '0) begin
			h_eff = RW'(1);
		end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
			h_eff = RW'(MAX_HEIGHT);
		end else begin
			h_eff = RW'(cfg_height);
		end
		h_plus1 = h_eff + RW'(1);

		// position left over from a different frame size: start over
		restart = (ic_q >= w_eff) || (ir_q > h_plus1) || ((ir_q == h_plus1) && (ic_q != '0));
		ic0 = restart ? '0 : ic_q;
		ir0 = restart ? '0 : ir_q;

		in_frame = ir0 < h_eff;
		drop     = in_frame && (cmd == CMD_FLUSH);

		// column 0 closes the right edge of the row two above
		emit_edge = (ic0 == '0) && (ir0 >= RW'(2));
		emit_main = (ic0 != '0) && (ir0 != '0);
		emit      = emit_edge || emit_main;
		if (emit_edge) begin
			orow = ir0 - RW'(2);
			ocol = w_eff - CW'(1);
		end else begin
			orow = ir0 - RW'(1);
			ocol = ic0 - CW'(1);
		end
		last = emit && (orow == h_eff - RW'(1)) && (ocol == w_eff - CW'(1));

		ic_nxt = ic0 + CW'(1);
		ir_nxt = ir0;
		if (ic_nxt >= w_eff) begin
			ic_nxt = '0;
			ir_nxt = ir0 + RW'(1);
		end
		if (last) begin
			ic_nxt = '0;
			ir_nxt = '0;
		end

		item.pix        = in_frame ? in_pixel : '0;
		item.emit       = emit;
		item.last       = last;
		item.pad.top    = orow == '0;
		item.pad.bottom = orow >= h_eff - RW'(1);
		item.pad.left   = ocol == '0;
		item.pad.right  = ocol >= w_eff - CW'(1);
		item.row        = POS_W'(orow);
		item.col        = POS_W'(ocol);
	end

	assign push = take && !drop;
	assign addr = ic0[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ic_q <= '0;
			ir_q <= '0;
		end else if (take) begin
			if (drop) begin
				ic_q <= ic0;
				ir_q <= ir0;
			end else begin
				ic_q <= ic_nxt;
				ir_q <= ir_nxt;
			end
		end
	end

	`CNP_ASSERT_NEXT(a_last_rewinds, push && item.last, (ic_q == '0) && (ir_q == '0), "frame end did not rewind counters")

endmodule

### design/cnp_line_buf.sv
`include "conv3x3_nibble_pixels_assert.svh"

module cnp_line_buf import cnp_pkg::*; #(
	parameter int MAX_WIDTH = 512,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  logic [AW-1:0] addr,
	input  pos_item_t item,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output win_item_t out_item
);

	// entry = {two rows above, one row above}
	logic [2*PIX_W-1:0] mem [MAX_WIDTH];

	logic               v1_q, v2_q, fwd_s1, ready2, adv1;
	pos_item_t          item_s1;
	logic [AW-1:0]      addr_s1;
	logic [2*PIX_W-1:0] rd_s1, fwd_data_s1;
	logic [PIX_W-1:0]   top, mid;
	grid_t              win_q, grid_cur;
	win_item_t          item_s2;

	assign ready2    = !v2_q || out_ready;
	assign adv1      = v1_q && ready2;
	assign in_ready  = !v1_q || ready2;
	assign {top, mid} = fwd_s1 ? fwd_data_s1 : rd_s1;

	always_ff @(posedge clk) begin
		if (push) begin
			rd_s1 <= mem[addr];
		end
		if (adv1) begin
			mem[addr_s1] <= {mid, item_s1.pix};
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			grid_cur[r][0] = win_q[r][1];
			grid_cur[r][1] = win_q[r][2];
		end
		grid_cur[0][2] = top;
		grid_cur[1][2] = mid;
		grid_cur[2][2] = item_s1.pix;
		if (item_s1.pad.top) begin
			grid_cur[0] = '0;
		end
		if (item_s1.pad.bottom) begin
			grid_cur[2] = '0;
		end
		for (int r = 0; r < 3; r++) begin
			if (item_s1.pad.left) begin
				grid_cur[r][0] = '0;
			end
			if (item_s1.pad.right) begin
				grid_cur[r][2] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_s1     <= item;
			addr_s1     <= addr;
			fwd_data_s1 <= {mid, item_s1.pix};
		end
		if (adv1 && item_s1.emit) begin
			item_s2.grid <= grid_cur;
			item_s2.row  <= item_s1.row;
			item_s2.col  <= item_s1.col;
			item_s2.last <= item_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q   <= 1'b0;
			v2_q   <= 1'b0;
			fwd_s1 <= 1'b0;
			win_q  <= '0;
		end else begin
			if (in_ready) begin
				v1_q <= push;
			end
			// read and write-back of the same entry on one edge: bypass the old data
			if (push) begin
				fwd_s1 <= adv1 && (addr == addr_s1);
			end
			if (ready2) begin
				v2_q <= adv1 && item_s1.emit;
			end
			if (adv1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[0][2] <= top;
				win_q[1][2] <= mid;
				win_q[2][2] <= item_s1.pix;
			end
		end
	end

	assign out_valid = v2_q;
	assign out_item  = item_s2;

	`CNP_ASSERT_NOW(a_no_push_on_stall, v1_q && !ready2, !push, "item taken while window stage stalled")
	`CNP_ASSERT_NEXT(a_bypass_needs_write, push && !adv1, !fwd_s1, "bypass set without a write-back")

endmodule

### design/cnp_mac.sv
`include "conv3x3_nibble_pixels_assert.svh"

module cnp_mac import cnp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  kernel_t   kernel,
	input  logic      in_valid,
	input  win_item_t in_item,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output result_t   result
);

	localparam logic signed [TOTAL_W-1:0] SAT_LEVEL = TOTAL_W'(PIX_MAX);

	logic [2:0][KROW_W-1:0]     krows;
	logic [2:0][ROWSUM_W-1:0]   rowsum_cur, rowsum_s3;
	logic signed [COEF_W-1:0]   coef;
	logic signed [PIX_W:0]      pel;
	logic signed [ROWSUM_W-1:0] acc;
	logic signed [TOTAL_W-1:0]  total, shifted;
	logic [POS_W-1:0]           row_s3, col_s3;
	logic                       last_s3, v3_q, vout_q, ready3, ready_out, adv3;
	logic [PIX_W-1:0]           pix_cur;
	result_t                    result_q;

	assign krows     = {kernel.bot, kernel.mid, kernel.top};
	assign ready_out = !vout_q || out_ready;
	assign ready3    = !v3_q || ready_out;
	assign adv3      = v3_q && ready_out;
	assign in_ready  = ready3;

	// one kernel row per sum: three 10x5 signed products
	always_comb begin
		coef = '0;
		pel  = '0;
		acc  = '0;
		for (int r = 0; r < 3; r++) begin
			acc = '0;
			for (int c = 0; c < 3; c++) begin
				coef = krows[r][c*COEF_W +: COEF_W];
				pel  = $signed({1'b0, in_item.grid[r][c]});
				acc  = acc + ROWSUM_W'(coef) * ROWSUM_W'(pel);
			end
			rowsum_cur[r] = acc;
		end
	end

	always_comb begin
		total = TOTAL_W'($signed(rowsum_s3[0])) + TOTAL_W'($signed(rowsum_s3[1]))
			+ TOTAL_W'($signed(rowsum_s3[2]));
		shifted = total >>> COEF_FRAC_BITS;
		if (total <= 0) begin
			pix_cur = '0;
		end else if (shifted > SAT_LEVEL) begin
			pix_cur = PIX_W'(PIX_MAX);
		end else begin
			pix_cur = shifted[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready3) begin
			rowsum_s3 <= rowsum_cur;
			row_s3    <= in_item.row;
			col_s3    <= in_item.col;
			last_s3   <= in_item.last;
		end
		if (adv3) begin
			result_q.pixel <= pix_cur;
			result_q.row   <= row_s3;
			result_q.col   <= col_s3;
			result_q.last  <= last_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q   <= 1'b0;
			vout_q <= 1'b0;
		end else begin
			if (ready3) begin
				v3_q <= in_valid;
			end
			if (ready_out) begin
				vout_q <= v3_q;
			end
		end
	end

	assign out_valid = vout_q;
	assign result    = result_q;

	`CNP_ASSERT_NEXT(a_sum_stage_holds, v3_q && !ready_out, v3_q && $stable(rowsum_s3), "row sums lost under stall")

endmodule

### tb/conv_check_pkg.sv
package conv_check_pkg;
	import cnp_pkg::*;

	localparam int LINE_MAX     = 512;
	localparam int ROWS_MAX     = 512;
	localparam int REPORT_LIMIT = 10;

	class conv_pixel_checker;
		logic [DIM_W-1:0]  width_reg;
		logic [DIM_W-1:0]  height_reg;
		logic [KROW_W-1:0] kernel_rows [3];
		logic [PIX_W-1:0]  line_prev [LINE_MAX];   // one row above the newest pixel per column
		logic [PIX_W-1:0]  line_older [LINE_MAX];  // two rows above
		grid_t             win;
		int                in_col;
		int                in_row;
		result_t           pending_pixels [$];
		int unsigned       fails;

		function new();
			width_reg  = 10'd160;
			height_reg = 10'd120;
			foreach (kernel_rows[i])
				kernel_rows[i] = 30'd7347207;
			foreach (line_prev[i]) begin
				line_prev[i]  = '0;
				line_older[i] = '0;
			end
			win    = '0;
			in_col = 0;
			in_row = 0;
			fails  = 0;
		endfunction

		function int eff_width();
			if (width_reg == 0)
				return 1;
			if (width_reg > LINE_MAX)
				return LINE_MAX;
			return int'(width_reg);
		endfunction

		function int eff_height();
			if (height_reg == 0)
				return 1;
			if (height_reg > ROWS_MAX)
				return ROWS_MAX;
			return int'(height_reg);
		endfunction

		function void set_reg(cfg_reg_t idx, logic [KROW_W-1:0] val);
			case (idx)
				REG_FRAME_WIDTH:   width_reg = val[DIM_W-1:0];
				REG_FRAME_HEIGHT:  height_reg = val[DIM_W-1:0];
				REG_KERNEL_TOP:    kernel_rows[0] = val;
				REG_KERNEL_MIDDLE: kernel_rows[1] = val;
				REG_KERNEL_BOTTOM: kernel_rows[2] = val;
				default: ;
			endcase
		endfunction

		// kernel sum over the neighborhood of (orow, ocol), zero outside the frame
		function logic [PIX_W-1:0] weigh(grid_t g, int orow, int ocol, int w, int h);
			int acc;
			int p;
			int r, c;
			bit pad;
			acc = 0;
			for (r = 0; r < 3; r++) begin
				for (c = 0; c < 3; c++) begin
					pad = (r == 0 && orow == 0) || (r == 2 && orow + 1 >= h) ||
					      (c == 0 && ocol == 0) || (c == 2 && ocol + 1 >= w);
					p = pad ? 0 : int'(g[r][c]);
					acc += $signed(kernel_rows[r][COEF_W*c +: COEF_W]) * p;
				end
			end
			if (acc <= 0)
				return '0;
			acc = acc >>> COEF_FRAC_BITS;
			return (acc > PIX_MAX) ? PIX_W'(PIX_MAX) : PIX_W'(acc);
		endfunction

		// returns 0 when the block drops the item
		function bit note_item(cmd_t cmd, logic [PIX_W-1:0] pix);
			int w, h, ir, ic, orow, ocol, r;
			logic [PIX_W-1:0] p, above, mid;
			grid_t g;
			result_t res;
			bit emit;
			w = eff_width();
			h = eff_height();
			// a size change can leave the position outside the frame
			if (in_col >= w || in_row > h + 1 || (in_row == h + 1 && in_col != 0)) begin
				in_col = 0;
				in_row = 0;
			end
			ir   = in_row;
			ic   = in_col;
			emit = 1'b0;
			orow = 0;
			ocol = 0;
			res  = '0;
			if (ir < h && cmd == CMD_FLUSH)
				return 1'b0;
			p = (ir < h) ? pix : '0;

			// right-edge pixel of the row before last, taken before the window shifts
			if (ic == 0 && ir >= 2) begin
				g = '0;
				for (r = 0; r < 3; r++) begin
					g[r][0] = win[r][1];
					g[r][1] = win[r][2];
				end
				orow      = ir - 2;
				ocol      = w - 1;
				res.pixel = weigh(g, orow, ocol, w, h);
				emit      = 1'b1;
			end

			above          = line_older[ic];
			mid            = line_prev[ic];
			line_older[ic] = mid;
			line_prev[ic]  = p;
			for (r = 0; r < 3; r++) begin
				win[r][0] = win[r][1];
				win[r][1] = win[r][2];
			end
			win[0][2] = above;
			win[1][2] = mid;
			win[2][2] = p;

			if (ic >= 1 && ir >= 1) begin
				orow      = ir - 1;
				ocol      = ic - 1;
				res.pixel = weigh(win, orow, ocol, w, h);
				emit      = 1'b1;
			end

			ic++;
			if (ic >= w) begin
				ic = 0;
				ir++;
			end
			in_col = ic;
			in_row = ir;

			if (emit) begin
				res.row  = orow[POS_W-1:0];
				res.col  = ocol[POS_W-1:0];
				res.last = (orow == h - 1) && (ocol == w - 1);
				if (res.last) begin
					in_col = 0;
					in_row = 0;
				end
				pending_pixels.push_back(res);
			end
			return 1'b1;
		endfunction

		function void check_pixel(logic [23:0] data, logic last);
			result_t got, want;
			got.pixel = data[PIX_W-1:0];
			got.row   = data[PIX_W +: POS_W];
			got.col   = data[PIX_W+POS_W +: POS_W];
			got.last  = last;
			if (pending_pixels.size() == 0) begin
				fails++;
				if (fails <= REPORT_LIMIT)
					$display("%0t: unexpected pixel: value %0d row %0d col %0d last %0b",
						$time, got.pixel, got.row, got.col, got.last);
				return;
			end
			want = pending_pixels.pop_front();
			if (got.pixel !== want.pixel || got.row !== want.row ||
			    got.col !== want.col || got.last !== want.last) begin
				fails++;
				if (fails <= REPORT_LIMIT) begin
					$display("%0t: pixel mismatch: expected value %0d row %0d col %0d last %0b",
						$time, want.pixel, want.row, want.col, want.last);
					$display("%0t: pixel mismatch: got value %0d row %0d col %0d last %0b",
						$time, got.pixel, got.row, got.col, got.last);
				end
			end
		endfunction
	endclass

endpackage

### tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cnp_pkg::*;
	import conv_check_pkg::*;

	localparam int     CLK_PERIOD    = 8;
	localparam int     ITEM_TARGET   = 1850;
	localparam int     SETTLE_CYCLES = 10;
	localparam int     DRAIN_GUARD   = 20000;
	localparam int     HOLD_CYCLES   = 300;
	localparam int     MAX_GAP       = 16;
	localparam longint TIMEOUT_NS    = 5000000;

	typedef enum int {
		IDLE_NONE,
		IDLE_ALWAYS,
		IDLE_SOMETIMES
	} idle_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [29:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;

	idle_t src_mode     = IDLE_NONE;
	idle_t sink_mode    = IDLE_NONE;
	bit    hold_request = 1'b0;
	int    items_done   = 0;

	conv_pixel_checker pix_chk = new();

	conv3x3_nibble_pixels u_top (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int draw_gap(idle_t mode);
		case (mode)
			IDLE_NONE:   return 0;
			IDLE_ALWAYS: return $urandom_range(0, MAX_GAP);
			default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
		endcase
	endfunction

	function automatic logic [PIX_W-1:0] draw_pixel();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return PIX_W'(PIX_MAX);
			default: return PIX_W'($urandom);
		endcase
	endfunction

	// raw register value; zero clamps to one inside the block
	function automatic logic [KROW_W-1:0] draw_size(int top);
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return KROW_W'($urandom_range(1, 2));
			default: return KROW_W'($urandom_range(3, top));
		endcase
	endfunction

	function automatic logic [KROW_W-1:0] draw_kernel_row();
		logic [KROW_W-1:0] row;
		int style;
		int k;
		style = $urandom_range(0, 2);
		for (k = 0; k < 3; k++) begin
			case (style)
				0:       row[k*COEF_W +: COEF_W] = COEF_W'($urandom);
				1:       row[k*COEF_W +: COEF_W] = COEF_W'($urandom_range(0, 24));
				default: row[k*COEF_W +: COEF_W] = COEF_W'($urandom_range(0, 192) - 96);
			endcase
		end
		return row;
	endfunction

	// called and returns at a falling edge
	task automatic write_reg(cfg_reg_t idx, logic [KROW_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		pix_chk.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic push_item(cmd_t cmd, logic [PIX_W-1:0] pix);
		int gap;
		gap = draw_gap(src_mode);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'b0, pix};
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
		if (pix_chk.note_item(cmd, pix))
			items_done++;
		@(negedge clk);
	endtask

	// pushes pixels with random dropped flushes in between, then drains
	task automatic stream_frame(int pushes, int drains, int noise_pct);
		int i;
		for (i = 0; i < pushes; i++) begin
			if ($urandom_range(0, 99) < noise_pct)
				push_item(CMD_FLUSH, PIX_W'($urandom));
			push_item(CMD_PUSH, draw_pixel());
		end
		// a push past the frame acts as a flush
		for (i = 0; i < drains; i++) begin
			if ($urandom_range(0, 3) == 0)
				push_item(CMD_PUSH, draw_pixel());
			else
				push_item(CMD_FLUSH, draw_pixel());
		end
	endtask

	task automatic drain_results();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (pix_chk.pending_pixels.size() != 0 && guard < DRAIN_GUARD) begin
			@(negedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : sink
		int gap;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				gap          = HOLD_CYCLES;
				hold_request = 1'b0;
			end else
				gap = draw_gap(sink_mode);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (m_tvalid !== 1'b1)
				@(posedge clk);
			pix_chk.check_pixel(m_tdata, m_tlast);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int n, w, h, frames, noise;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// 3x3 frame on the reset kernel
		write_reg(REG_FRAME_WIDTH, 30'd3);
		write_reg(REG_FRAME_HEIGHT, 30'd3);
		push_item(CMD_FLUSH, 4'h0);   // dropped, frame not yet complete
		for (n = 0; n < 9; n++)
			push_item(CMD_PUSH, n[0] ? 4'h0 : 4'hF);
		push_item(CMD_PUSH, 4'h5);    // past the frame
		repeat (3) push_item(CMD_FLUSH, 4'hA);
		drain_results();

		// coefficient extremes on a 2x2 frame
		write_reg(REG_KERNEL_TOP,    {10'h1FF, 10'h200, 10'h001});
		write_reg(REG_KERNEL_MIDDLE, {10'h000, 10'h040, 10'h3FF});
		write_reg(REG_KERNEL_BOTTOM, {10'h200, 10'h1FF, 10'h1FF});
		write_reg(REG_FRAME_WIDTH, 30'd2);
		write_reg(REG_FRAME_HEIGHT, 30'd2);
		push_item(CMD_PUSH, 4'hF);
		push_item(CMD_PUSH, 4'hF);
		push_item(CMD_PUSH, 4'h0);
		push_item(CMD_PUSH, 4'hF);
		repeat (3) push_item(CMD_FLUSH, 4'h0);
		drain_results();

		// zero sizes clamp to one pixel; the first flush of a one-row frame yields nothing
		write_reg(REG_FRAME_WIDTH, 30'd0);
		write_reg(REG_FRAME_HEIGHT, 30'd0);
		push_item(CMD_PUSH, 4'h9);
		push_item(CMD_FLUSH, 4'h0);
		push_item(CMD_FLUSH, 4'h0);
		drain_results();

		// widest and tallest frames, kept one pixel thin
		src_mode  = IDLE_SOMETIMES;
		sink_mode = IDLE_SOMETIMES;
		write_reg(REG_KERNEL_MIDDLE, draw_kernel_row());
		write_reg(REG_FRAME_WIDTH, 30'd1023);
		write_reg(REG_FRAME_HEIGHT, 30'd1);
		stream_frame(LINE_MAX, LINE_MAX + 1, 2);
		drain_results();
		write_reg(REG_FRAME_WIDTH, 30'd1);
		write_reg(REG_FRAME_HEIGHT, 30'd1023);
		stream_frame(ROWS_MAX, 2, 2);
		drain_results();

		n = 0;
		while (n == 0 || items_done < ITEM_TARGET) begin
			drain_results();
			src_mode  = idle_t'($urandom_range(0, 2));
			sink_mode = idle_t'($urandom_range(0, 2));
			noise     = $urandom_range(0, 10);
			if (n == 0) begin
				// long receiver stall while the sender keeps offering items
				src_mode     = IDLE_NONE;
				hold_request = 1'b1;
				write_reg(REG_FRAME_WIDTH, 30'd16);
				write_reg(REG_FRAME_HEIGHT, 30'd6);
				stream_frame(16 * 6, 17, 0);
			end else begin
				if ($urandom_range(0, 2) != 0)
					write_reg(REG_FRAME_WIDTH, draw_size(14));
				if ($urandom_range(0, 2) != 0)
					write_reg(REG_FRAME_HEIGHT, draw_size(8));
				if ($urandom_range(0, 1) != 0)
					write_reg(REG_KERNEL_TOP, draw_kernel_row());
				if ($urandom_range(0, 1) != 0)
					write_reg(REG_KERNEL_MIDDLE, draw_kernel_row());
				if ($urandom_range(0, 1) != 0)
					write_reg(REG_KERNEL_BOTTOM, draw_kernel_row());
				w      = pix_chk.eff_width();
				h      = pix_chk.eff_height();
				frames = $urandom_range(1, 3);
				repeat (frames) begin
					// a cut frame leaves the block mid-frame for the next setting
					if ($urandom_range(0, 5) == 0)
						stream_frame($urandom_range(1, w * h), 0, noise);
					else
						stream_frame(w * h, w + 1, noise);
				end
			end
			n++;
		end

		drain_results();
		if (pix_chk.fails == 0 && pix_chk.pending_pixels.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

endmodule
